@@ src/adwm_pkg.sv @@
// ----------------------------------------------------------------------------
// adwm_pkg: shared types and constants of the DNA window matcher
// Transaction structs, register indexes and the scan token carried by the
// cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package adwm_pkg;

    localparam int DEF_MAX_PATTERN = 32;
    localparam int DEF_POS_WIDTH   = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LIM_W      = 6;
    // counts up to 127 mismatches
    localparam int CNT_W      = 7;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN   = 3'd3;

    localparam logic [LIM_W-1:0] LENGTH_RST    = 6'd32;
    localparam logic [LIM_W-1:0] MAX_TOTAL_RST = 6'd3;
    localparam logic [LIM_W-1:0] MAX_RUN_RST   = 6'd0;

    typedef struct packed {
        logic [1:0] base;
        logic       last_base;
    } t_in;

    typedef struct packed {
        logic [31:0] position;
        logic        forward_match;
        logic        reverse_match;
        logic [31:0] match_number;
    } t_out;

    typedef struct packed {
        logic [CNT_W-1:0] tot;
        logic [CNT_W-1:0] run;
        logic             ok;
    } t_dir;

    typedef struct packed {
        logic valid;
        t_dir fwd;
        t_dir rev;
    } t_tok;

    // pattern base j, zero above the 32 bases of the register
    function automatic logic [1:0] pat_base(input logic [63:0] pattern,
                                            input logic [6:0]  j);
        logic [1:0] b;
        b = 2'd0;
        if (j < 7'd32) begin
            b = pattern[{j[4:0], 1'b0} +: 2];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ src/adwm_cell.sv @@
// ----------------------------------------------------------------------------
// adwm_cell: one window cell
// Holds one window base, shifts it on to the next cell and updates the scan
// token for both directions as it passes.
// ----------------------------------------------------------------------------
`default_nettype none

module adwm_cell
    import adwm_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W      = $clog2(MAX_PATTERN)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_shift,
    input  wire logic              i_clear,
    input  wire logic [1:0]        i_base,
    output logic      [1:0]        o_base,
    input  wire t_tok              i_tok,
    output t_tok                   o_tok,
    input  wire logic [63:0]       i_pattern,
    input  wire logic [IDX_W-1:0]  i_len_m1,
    input  wire logic [LIM_W-1:0]  i_max_tot,
    input  wire logic [LIM_W-1:0]  i_max_run
);

    logic [1:0]       r_base;
    t_tok             r_tok;
    t_tok             n_tok;
    logic [IDX_W-1:0] w_fwd_idx;
    logic             w_mm_fwd;
    logic             w_mm_rev;

    function automatic t_dir dir_step(input t_dir d, input logic mm,
                                      input logic [LIM_W-1:0] mt,
                                      input logic [LIM_W-1:0] mr);
        t_dir r;
        r.run = mm ? d.run + CNT_W'(1) : '0;
        r.tot = d.tot + CNT_W'(mm);
        r.ok  = d.ok & ~(mm & ((r.run > CNT_W'(mr)) | (r.tot > CNT_W'(mt))));
        return r;
    endfunction

    // forward compare pairs this cell with pattern base len-1-idx
    assign w_fwd_idx = i_len_m1 - IDX_W'(CELL_IDX);
    assign w_mm_fwd  = r_base != pat_base(i_pattern, 7'(w_fwd_idx));
    assign w_mm_rev  = r_base != pat_base(i_pattern, 7'(CELL_IDX));

    always_comb begin
        n_tok       = i_tok;
        n_tok.fwd   = dir_step(i_tok.fwd, w_mm_fwd, i_max_tot, i_max_run);
        n_tok.rev   = dir_step(i_tok.rev, w_mm_rev, i_max_tot, i_max_run);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 2'd0;
            r_tok  <= '0;
        end else begin
            if (i_clear) begin
                r_base <= 2'd0;
            end else if (i_shift) begin
                r_base <= i_base;
            end
            r_tok <= n_tok;
        end
    end

    assign o_base = r_base;
    assign o_tok  = r_tok;

endmodule

`default_nettype wire

@@ src/approx_dna_window_matcher_top.sv @@
// ----------------------------------------------------------------------------
// approx_dna_window_matcher_top: k-mismatch window matcher, forward and reverse
// Streams 2-bit bases through a chain of window cells and reports windows
// that match the configured pattern within the mismatch limits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one base per transaction,
//   with last_base marking the end of a sequence. Output channel
//   (o_out_valid / i_out_ready) gives one result transaction per matching
//   window. Configuration writes (i_cfg_valid / o_cfg_ready) set the pattern,
//   its length and the two mismatch limits; the user must write them only
//   while the block is idle, as the block itself does not enforce it.
//   While the window is not yet full a base is taken without a scan. Once it
//   is full, a scan token walks the cell chain one cell per cycle through
//   the active cells; the verdict is then captured from the last active cell
//   and the output register is loaded with the result. The next base is
//   taken only once the scan is done and the block is idle again.
//   The output register lets the next base enter while a result waits; a
//   stalled receiver holds the block only when a second result is ready.
//   Reset clears the window, the counters and the output valid flag, and
//   loads the register defaults (length 32, total limit 3, run limit 0).
//   After the last base of a sequence, window and counters return to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module approx_dna_window_matcher_top
    import adwm_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int POS_WIDTH   = DEF_POS_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out
);

    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [63:0]          r_pattern;
    logic [LIM_W-1:0]     r_plen;
    logic [LIM_W-1:0]     r_max_tot;
    logic [LIM_W-1:0]     r_max_run;
    logic [LEN_W-1:0]     r_fill;
    logic [POS_WIDTH-1:0] r_base_cnt;
    logic [POS_WIDTH-1:0] r_match_cnt;
    logic [POS_WIDTH-1:0] r_pos;
    logic                 r_launch;
    logic                 r_last;
    logic                 r_fwd;
    logic                 r_rev;
    logic                 r_out_vld;
    t_out                 r_out;

    logic [LEN_W-1:0]       w_len;
    logic [IDX_W-1:0]       w_len_m1;
    logic [LEN_W-1:0]       w_fill_inc;
    logic                   w_full;
    logic                   w_accept;
    logic                   w_hit;
    logic                   w_out_free;
    logic                   w_finish;
    logic                   w_load;
    logic                   w_clear;
    t_tok                   w_sel;
    t_tok                   w_tok_head;
    logic [POS_WIDTH+31:0]  w_pos_ext;
    logic [POS_WIDTH+31:0]  w_num_ext;

    logic [1:0] w_base  [MAX_PATTERN];
    t_tok       w_tok   [MAX_PATTERN];

    // effective pattern length, clamped to 1..MAX_PATTERN
    always_comb begin
        if (r_plen == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_plen) > MAX_PATTERN) begin
            w_len = LEN_W'(MAX_PATTERN);
        end else begin
            w_len = LEN_W'(r_plen);
        end
    end
    assign w_len_m1 = IDX_W'(w_len - LEN_W'(1));

    assign w_fill_inc = (r_fill < LEN_W'(MAX_PATTERN)) ? r_fill + LEN_W'(1) : r_fill;
    assign w_full     = w_fill_inc >= w_len;
    assign o_in_ready = r_state == ST_IDLE;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_sel      = w_tok[w_len_m1];
    assign w_hit      = r_fwd | r_rev;
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_finish   = (r_state == ST_HOLD) && (!w_hit || w_out_free);
    assign w_load     = (r_state == ST_HOLD) && w_hit && w_out_free;
    assign w_clear    = (w_accept && !w_full && i_in.last_base) || (w_finish && r_last);

    always_comb begin
        w_tok_head         = '0;
        w_tok_head.valid   = r_launch;
        w_tok_head.fwd.ok  = 1'b1;
        w_tok_head.rev.ok  = 1'b1;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
            adwm_cell #(
                .MAX_PATTERN (MAX_PATTERN),
                .CELL_IDX    (gi)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_shift   (w_accept),
                .i_clear   (w_clear),
                .i_base    ((gi == 0) ? i_in.base : w_base[(gi == 0) ? 0 : gi - 1]),
                .o_base    (w_base[gi]),
                .i_tok     ((gi == 0) ? w_tok_head : w_tok[(gi == 0) ? 0 : gi - 1]),
                .o_tok     (w_tok[gi]),
                .i_pattern (r_pattern),
                .i_len_m1  (w_len_m1),
                .i_max_tot (r_max_tot),
                .i_max_run (r_max_run)
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_full) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_sel.valid) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= LENGTH_RST;
            r_max_tot <= MAX_TOTAL_RST;
            r_max_run <= MAX_RUN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PATTERN:   r_pattern <= i_cfg_data;
                REG_LENGTH:    r_plen    <= i_cfg_data[LIM_W-1:0];
                REG_MAX_TOTAL: r_max_tot <= i_cfg_data[LIM_W-1:0];
                REG_MAX_RUN:   r_max_run <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_base_cnt  <= '0;
            r_match_cnt <= '0;
            r_launch    <= 1'b0;
            r_last      <= 1'b0;
            r_fwd       <= 1'b0;
            r_rev       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept && w_full;

            if (w_accept) begin
                r_last <= i_in.last_base;
                r_pos  <= r_base_cnt - POS_WIDTH'(w_len_m1);
                if (i_in.last_base) begin
                    r_fill     <= '0;
                    r_base_cnt <= '0;
                end else begin
                    r_fill     <= w_fill_inc;
                    r_base_cnt <= r_base_cnt + POS_WIDTH'(1);
                end
            end

            // capture the verdict as the token leaves the last active cell
            if (r_state == ST_SCAN && w_sel.valid) begin
                r_fwd <= w_sel.fwd.ok;
                r_rev <= w_sel.rev.ok;
            end

            if ((w_accept && !w_full && i_in.last_base) || (w_finish && r_last)) begin
                r_match_cnt <= '0;
            end else if (w_load) begin
                r_match_cnt <= r_match_cnt + POS_WIDTH'(1);
            end

            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign w_pos_ext = {32'b0, r_pos};
    assign w_num_ext = {32'b0, r_match_cnt};

    // output payload, held until taken
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.position      <= w_pos_ext[31:0];
            r_out.forward_match <= r_fwd;
            r_out.reverse_match <= r_rev;
            r_out.match_number  <= w_num_ext[31:0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ verif/approx_dna_window_matcher_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// approx_dna_window_matcher_top_tb: self-checking bench for the window matcher
// Streams bases through the matcher under a series of pattern, length and
// mismatch-limit settings. A scoreboard tracks the base window and the
// counters, predicts every match result and checks each output transaction.
// ----------------------------------------------------------------------------

class window_match_scoreboard;
    logic [63:0]    pattern;
    logic [5:0]     pat_len;
    logic [5:0]     lim_total;
    logic [5:0]     lim_run;
    logic [1:0]     window [32];
    int             fill;
    logic [31:0]    base_idx;
    logic [31:0]    match_idx;
    adwm_pkg::t_out expected_matches [$];
    int             errors;
    int             checked;

    function new();
        pattern   = '0;
        pat_len   = adwm_pkg::LENGTH_RST;
        lim_total = adwm_pkg::MAX_TOTAL_RST;
        lim_run   = adwm_pkg::MAX_RUN_RST;
        errors    = 0;
        checked   = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        foreach (window[i]) window[i] = 2'd0;
        fill      = 0;
        base_idx  = '0;
        match_idx = '0;
    endfunction

    function void apply_reg(logic [adwm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        case (idx)
            adwm_pkg::REG_PATTERN:   pattern   = data;
            adwm_pkg::REG_LENGTH:    pat_len   = data[5:0];
            adwm_pkg::REG_MAX_TOTAL: lim_total = data[5:0];
            adwm_pkg::REG_MAX_RUN:   lim_run   = data[5:0];
            default: ;
        endcase
    endfunction

    // length 0 acts as 1, anything above 32 as 32
    function int active_length();
        if (pat_len == 6'd0) return 1;
        if (pat_len > 6'd32) return 32;
        return int'(pat_len);
    endfunction

    function bit window_passes(int len, bit reversed);
        int         total;
        int         run;
        int         k;
        bit         ok;
        logic [1:0] want;
        total = 0;
        run   = 0;
        ok    = 1'b1;
        for (k = 0; k < len; k++) begin
            want = pattern[2 * (reversed ? len - 1 - k : k) +: 2];
            // window entry 0 is the newest base
            if (window[len - 1 - k] != want) begin
                run++;
                total++;
                if (run > int'(lim_run) || total > int'(lim_total)) ok = 1'b0;
            end else begin
                run = 0;
            end
        end
        return ok;
    endfunction

    function void note_base(adwm_pkg::t_in item);
        int             len;
        int             i;
        bit             fwd;
        bit             rev;
        adwm_pkg::t_out want;
        len = active_length();
        for (i = 31; i > 0; i--) window[i] = window[i - 1];
        window[0] = item.base;
        if (fill < 32) fill++;
        if (fill >= len) begin
            fwd = window_passes(len, 1'b0);
            rev = window_passes(len, 1'b1);
            if (fwd || rev) begin
                want.position      = base_idx - 32'(len - 1);
                want.forward_match = fwd;
                want.reverse_match = rev;
                want.match_number  = match_idx;
                expected_matches.push_back(want);
                match_idx++;
            end
        end
        base_idx++;
        if (item.last_base) clear_stream();
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_match(adwm_pkg::t_out got);
        adwm_pkg::t_out want;
        if (expected_matches.size() == 0) begin
            report($sformatf("unexpected result: pos=%0d fwd=%0b rev=%0b num=%0d",
                             got.position, got.forward_match, got.reverse_match,
                             got.match_number));
        end else begin
            want = expected_matches.pop_front();
            checked++;
            if (got.position !== want.position
                    || got.forward_match !== want.forward_match
                    || got.reverse_match !== want.reverse_match
                    || got.match_number !== want.match_number) begin
                report($sformatf({"result mismatch: expected pos=%0d fwd=%0b rev=%0b num=%0d,",
                                  " got pos=%0d fwd=%0b rev=%0b num=%0d"},
                                 want.position, want.forward_match, want.reverse_match,
                                 want.match_number, got.position, got.forward_match,
                                 got.reverse_match, got.match_number));
            end
        end
    endfunction
endclass

module approx_dna_window_matcher_top_tb;
    import adwm_pkg::*;

    localparam int          MAXP            = 32;
    // two full scans of the longest window plus margin
    localparam int          SETTLE_CYCLES   = 2 * (MAXP + 3) + 10;
    localparam int          N_PHASES        = 12;
    localparam int          ITEMS_PER_PHASE = 66;
    localparam int unsigned CYCLE_LIMIT     = 500000;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    t_in                   in_item     = '0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  out_ready   = 1'b0;
    logic                  no_idle     = 1'b0;
    int unsigned           cycle_count = 0;
    int                    sent        = 0;

    logic                  o_in_ready;
    logic                  o_cfg_ready;
    logic                  o_out_valid;
    t_out                  o_out;

    window_match_scoreboard sb = new();

    approx_dna_window_matcher_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result sink: check each accepted transaction, stall at random
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) sb.check_match(o_out);
        out_ready <= no_idle || ($urandom_range(99) >= 16);
    end

    function automatic t_in base_item(logic [1:0] b, logic last);
        t_in item;
        item.base      = b;
        item.last_base = last;
        return item;
    endfunction

    task automatic send_base(input t_in item);
        while (!no_idle && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        sb.note_base(item);
        sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        sb.apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drain results, then let any scan that yields nothing run out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_matches.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n_items);
        t_in seg [$];
        t_in item;
        int  done;
        int  len;
        int  kind;
        int  cnt;
        int  mut;
        int  k;
        bit  rev;
        done = 0;
        while (done < n_items) begin
            seg.delete();
            len  = sb.active_length();
            kind = $urandom_range(99);
            if (kind >= 70 && kind < 85) begin
                cnt = $urandom_range(1, 8);
                for (k = 0; k < cnt; k++) begin
                    seg.push_back(base_item(2'($urandom_range(3)), 1'b0));
                end
            end else begin
                // full copy of the pattern, or a broken prefix of one
                cnt = (kind < 70) ? len : $urandom_range(1, len);
                rev = $urandom_range(1);
                case ($urandom_range(3))
                    0: mut = 0;
                    1: mut = 3;
                    2: mut = 10;
                    default: mut = 30;
                endcase
                for (k = 0; k < cnt; k++) begin
                    item = base_item(sb.pattern[2 * (rev ? len - 1 - k : k) +: 2], 1'b0);
                    if ($urandom_range(99) < mut) item.base = 2'($urandom_range(3));
                    seg.push_back(item);
                end
            end
            if ($urandom_range(99) < 15) seg[seg.size() - 1].last_base = 1'b1;
            foreach (seg[i]) send_base(seg[i]);
            done += seg.size();
        end
    endtask

    initial begin
        int          p;
        logic [63:0] pat;
        logic [63:0] hi;
        logic [5:0]  len_v;
        logic [5:0]  tot_v;
        logic [5:0]  run_v;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // short sequence under the reset settings: no result
        send_base(base_item(BASE_A, 1'b0));
        send_base(base_item(BASE_C, 1'b0));
        send_base(base_item(BASE_G, 1'b0));
        send_base(base_item(BASE_T, 1'b1));
        wait_idle();

        // pattern ACGT, exact match only; forward then reversed, last base hits
        write_reg(REG_PATTERN, 64'hFFFF_FFFF_FFFF_FFE4);
        write_reg(REG_LENGTH, 64'd4);
        write_reg(REG_MAX_TOTAL, 64'd0);
        write_reg(REG_MAX_RUN, 64'd0);
        write_reg(REG_UNUSED, '1);
        send_base(base_item(BASE_A, 1'b0));
        send_base(base_item(BASE_C, 1'b0));
        send_base(base_item(BASE_G, 1'b0));
        send_base(base_item(BASE_T, 1'b0));
        send_base(base_item(BASE_G, 1'b0));
        send_base(base_item(BASE_C, 1'b0));
        send_base(base_item(BASE_A, 1'b1));

        // change length within a sequence: zero acts as one, then limits above length
        send_base(base_item(BASE_A, 1'b0));
        send_base(base_item(BASE_C, 1'b0));
        send_base(base_item(BASE_G, 1'b0));
        wait_idle();
        write_reg(REG_LENGTH, 64'd0);
        send_base(base_item(BASE_A, 1'b0));
        send_base(base_item(BASE_C, 1'b0));
        wait_idle();
        write_reg(REG_LENGTH, 64'd6);
        write_reg(REG_MAX_TOTAL, 64'd63);
        write_reg(REG_MAX_RUN, 64'd63);
        send_base(base_item(BASE_T, 1'b1));

        for (p = 0; p < N_PHASES; p++) begin
            wait_idle();
            pat = {$urandom(), $urandom()};
            case (p)
                0: begin pat = '0; len_v = 6'd32; tot_v = 6'd3; run_v = 6'd0; end
                1: begin len_v = 6'd1;  tot_v = 6'd0;  run_v = 6'd0;  end
                2: begin len_v = 6'd32; tot_v = 6'd32; run_v = 6'd32; end
                3: begin len_v = 6'd63; tot_v = 6'd5;  run_v = 6'd2;  end
                4: begin len_v = 6'd0;  tot_v = 6'd0;  run_v = 6'd0;  end
                5: begin pat = '1; len_v = 6'd16; tot_v = 6'd4; run_v = 6'd1; end
                6: begin
                    len_v = 6'($urandom_range(33, 63));
                    tot_v = 6'd63;
                    run_v = 6'd0;
                end
                7: begin len_v = 6'd2; tot_v = 6'd1; run_v = 6'd1; end
                default: begin
                    len_v = 6'($urandom_range(63));
                    tot_v = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                     : 6'($urandom_range(6));
                    run_v = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                     : 6'($urandom_range(3));
                end
            endcase
            // odd phases carry junk above the register width
            hi = (p % 2 == 1) ? {$urandom(), $urandom()} : '0;
            write_reg(REG_PATTERN, pat);
            write_reg(REG_LENGTH, {hi[63:6], len_v});
            write_reg(REG_MAX_TOTAL, {hi[63:6], tot_v});
            write_reg(REG_MAX_RUN, {hi[63:6], run_v});
            no_idle <= (p == 3);
            run_phase(ITEMS_PER_PHASE);
        end

        wait_idle();
        $display("Streamed %0d bases over %0d setting phases, %0d match results checked.",
                 sent, N_PHASES, sb.checked);
        $display("Lengths 0 to 63, limits 0 to 63, forward and reversed copies, idling both sides.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ approx_dna_window_matcher_top.f @@
src/adwm_pkg.sv
src/adwm_cell.sv
src/approx_dna_window_matcher_top.sv
verif/approx_dna_window_matcher_top_tb.sv
